// ----- design/mftt_pkg.sv -----
// Package for the motor feedback turn tracker: beat types and fixed constants.
// No dependencies; used by every module of the block by scoped names.
`default_nettype none

package mftt_pkg;

    localparam int ANGLE_W = 13;
    localparam int SPEED_W = 16;
    localparam int CURR_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int SUM_W   = 32;
    localparam int TICK_W  = 16;
    localparam int ENC_MAX_W = 16;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [TICK_W-1:0] OFFLINE_LIMIT_RST = 16'd100;

    typedef struct packed {
        logic                      command;
        logic [ANGLE_W-1:0]        angle_raw;
        logic signed [SPEED_W-1:0] speed_rpm;
        logic signed [CURR_W-1:0]  current_raw;
        logic [TEMP_W-1:0]         temperature;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]   turn_sum;
        logic [ANGLE_W-1:0]        angle_out;
        logic signed [SPEED_W-1:0] speed_out;
        logic signed [CURR_W-1:0]  current_out;
        logic [TEMP_W-1:0]         temperature_out;
        logic                      online;
        logic [TICK_W-1:0]         missed_ticks;
    } out_item_t;

endpackage

`default_nettype wire

// ----- design/mftt_step.sv -----
// Next-state logic of the turn tracker: one frame or tick applied to the state.
// Depends on mftt_pkg for the beat types and constants.
`default_nettype none

module mftt_step #(
    parameter int ENC_BITS = 13
) (
    input  wire mftt_pkg::in_item_t               item,
    input  wire mftt_pkg::out_item_t              cur,
    input  wire logic [ENC_BITS-1:0]              last_angle,
    input  wire logic                             primed,
    input  wire logic [mftt_pkg::TICK_W-1:0]      limit,
    output mftt_pkg::out_item_t                   nxt,
    output logic [ENC_BITS-1:0]                   last_angle_next
);

    localparam int DW = ENC_BITS + 2;
    localparam logic signed [DW-1:0] HALF_M1 = DW'((1 << (ENC_BITS - 1)) - 1);
    localparam logic signed [DW-1:0] ENC_MOD = DW'(1 << ENC_BITS);

    logic [mftt_pkg::ENC_MAX_W-1:0] ang_ext;
    logic [ENC_BITS-1:0]            ang;
    logic [mftt_pkg::ENC_MAX_W-1:0] ang_wide;
    logic signed [DW-1:0]           diff_raw;
    logic signed [DW-1:0]           diff_adj;
    logic signed [mftt_pkg::SUM_W-1:0] diff_ext;
    logic [mftt_pkg::TICK_W:0]      tick_inc;

    // Reduce the encoder angle to one turn.
    assign ang_ext  = mftt_pkg::ENC_MAX_W'(item.angle_raw);
    assign ang      = ang_ext[ENC_BITS-1:0];
    assign ang_wide = mftt_pkg::ENC_MAX_W'(ang);

    // Unwrap the difference across zero when it reaches half a turn or more.
    assign diff_raw = $signed({2'b00, ang}) - $signed({2'b00, last_angle});

    always_comb
    begin
        if (!primed)
            diff_adj = '0;
        else if (diff_raw > HALF_M1)
            diff_adj = diff_raw - ENC_MOD;
        else if (diff_raw < -HALF_M1)
            diff_adj = diff_raw + ENC_MOD;
        else
            diff_adj = diff_raw;
    end

    assign diff_ext = {{(mftt_pkg::SUM_W - DW){diff_adj[DW-1]}}, diff_adj};
    assign tick_inc = {1'b0, cur.missed_ticks} + 17'd1;

    always_comb
    begin
        nxt             = cur;
        last_angle_next = last_angle;
        if (item.command == mftt_pkg::CMD_FRAME)
        begin
            nxt.turn_sum        = cur.turn_sum + diff_ext;
            nxt.angle_out       = ang_wide[mftt_pkg::ANGLE_W-1:0];
            nxt.speed_out       = item.speed_rpm;
            nxt.current_out     = item.current_raw;
            nxt.temperature_out = item.temperature;
            nxt.missed_ticks    = '0;
            last_angle_next     = ang;
        end
        else if (tick_inc > {1'b0, limit})
        begin
            // saturate at the limit and drop the link
            nxt.missed_ticks = limit;
            nxt.online       = 1'b0;
        end
        else
        begin
            nxt.missed_ticks = tick_inc[mftt_pkg::TICK_W-1:0];
            nxt.online       = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- design/motor_feedback_turn_tracker.sv -----
// Top level of the motor feedback turn tracker: input register, tracker state
// that doubles as the result register, and the offline limit register.
// Depends on mftt_pkg and mftt_step.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+------------------------------
//   in      | in        | in_valid / in_ready   | mftt_pkg::in_item_t
//   out     | out       | out_valid / out_ready | mftt_pkg::out_item_t
//   cfg     | in        | cfg_valid / cfg_ready | 16-bit offline limit
//
// One beat per cycle sustained while out is not stalled; a result passes the input
// register, then the state/result register, before it appears on out.
// The tracker state itself is the result register: it advances only when the
// previous result has been taken, so a stalled output holds the state too.
// A stall on out holds the input register, and in_ready drops only while the
// input register is full and cannot advance.
// Reset clears the state, the flags and sets the offline limit to 100;
// cfg_ready is always high.
`default_nettype none

module motor_feedback_turn_tracker #(
    parameter int ENC_BITS = 13
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire mftt_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output mftt_pkg::out_item_t                out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mftt_pkg::TICK_W-1:0]   cfg_data
);

    logic                          s1_valid_reg;
    mftt_pkg::in_item_t            s1_item_reg;
    logic                          out_valid_reg;
    mftt_pkg::out_item_t           track_reg;
    mftt_pkg::out_item_t           track_next;
    logic [ENC_BITS-1:0]           last_angle_reg;
    logic [ENC_BITS-1:0]           last_angle_next;
    logic                          primed_reg;
    logic [mftt_pkg::TICK_W-1:0]   limit_reg;
    logic                          advance;

    // Move the held beat into the state when the result slot is free.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = track_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= mftt_pkg::OFFLINE_LIMIT_RST;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    // Input register: capture a beat whenever the slot is free or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_item_reg <= in_data;
    end

    mftt_step #(
        .ENC_BITS(ENC_BITS)
    ) u_step (
        .item            (s1_item_reg),
        .cur             (track_reg),
        .last_angle      (last_angle_reg),
        .primed          (primed_reg),
        .limit           (limit_reg),
        .nxt             (track_next),
        .last_angle_next (last_angle_next)
    );

    // Tracker state and result valid; the state is architectural, so reset it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            track_reg      <= '0;
            last_angle_reg <= '0;
            primed_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                track_reg      <= track_next;
                last_angle_reg <= last_angle_next;
                if (s1_item_reg.command == mftt_pkg::CMD_FRAME)
                    primed_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- design/mftt_checker.sv -----
// Port-level checker for the motor feedback turn tracker, bound to the top.
// Depends on mftt_pkg and motor_feedback_turn_tracker.
`default_nettype none

module mftt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire mftt_pkg::out_item_t out_data,
    input wire logic                cfg_ready
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // an empty output slot never backs up the input
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // an accepted beat reaches the output through the state register when the slot is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
        else $error("accepted beat produced no result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind motor_feedback_turn_tracker mftt_checker u_mftt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
